// ----- hw/rtl/ols_pkg.sv -----
// ols_pkg: shared constants for the ordered list store
// list depth, derived widths, operation and status codes
// no dependencies
`default_nettype none

package ols_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int VAL_W      = 32;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_DELETE  = 2'd1;
  localparam logic [1:0] OP_DISPLAY = 2'd2;

  localparam logic [2:0] ST_INS_FIRST = 3'd0;
  localparam logic [2:0] ST_INS_END   = 3'd1;
  localparam logic [2:0] ST_DELETED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_ELEMENT   = 3'd6;

endpackage

`default_nettype wire

// ----- hw/rtl/ordered_list_store.sv -----
// ordered_list_store: bounded ordered list of signed 32-bit values
// entry memory with one write port and one read port, stepped by a small sequencer; uses ols_pkg
//
// One item is taken at a time; in_tready is high only while the sequencer is idle and the
// result register is empty. Insert gives one result (full when the list holds LIST_DEPTH
// entries). Delete scans the list entry by entry, each read through the one registered
// memory read port and then compared, then closes the gap by reading and writing back each
// moved entry; it gives one result: deleted, not found or empty. Display reads each entry
// and gives one element result per entry with tlast on the final one, or a single empty
// result; it stalls while a result is held and out_tready is low.
// Operation code 3 is accepted and dropped with no result.
`default_nettype none

module ordered_list_store import ols_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [VAL_W-1:0] in_tdata,   // [31:0] value
  input  wire logic [1:0]       in_tuser,   // [1:0] operation
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [VAL_W-1:0]      out_tdata,  // [31:0] item_value
  output logic [2:0]            out_tuser,  // [2:0] status
  output logic                  out_tlast
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SRCH_RD  = 3'd1;
  localparam logic [2:0] S_SRCH_CMP = 3'd2;
  localparam logic [2:0] S_SHIFT_RD = 3'd3;
  localparam logic [2:0] S_SHIFT_WR = 3'd4;
  localparam logic [2:0] S_DISP_RD  = 3'd5;
  localparam logic [2:0] S_DISP_OUT = 3'd6;

  logic [VAL_W-1:0] mem [LIST_DEPTH];
  logic [VAL_W-1:0] rd_data_r;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [VAL_W-1:0] key_r, key_nxt;

  logic             ovalid_r, ovalid_nxt;
  logic [VAL_W-1:0] odata_r, odata_nxt;
  logic [2:0]       ostat_r, ostat_nxt;
  logic             olast_r, olast_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic [IDX_W-1:0] rd_addr;

  logic             accept;
  logic             slot_free;
  logic [CNT_W-1:0] idx_inc;
  logic             at_end;

  assign in_tready  = (state_r == S_IDLE) && !ovalid_r;
  assign accept     = in_tvalid && in_tready;
  assign slot_free  = !ovalid_r || out_tready;
  assign idx_inc    = CNT_W'(idx_r) + CNT_W'(1);
  assign at_end     = (idx_inc >= count_r);
  assign rd_addr    = (state_r == S_SHIFT_RD) ? idx_r + IDX_W'(1) : idx_r;

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ostat_r;
  assign out_tlast  = olast_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    key_nxt    = key_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    ostat_nxt  = ostat_r;
    olast_nxt  = olast_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_data    = rd_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt = in_tdata;
          idx_nxt = '0;
          unique case (in_tuser)
            OP_INSERT: begin
              ovalid_nxt = 1'b1;
              olast_nxt  = 1'b1;
              if (count_r >= CNT_W'(LIST_DEPTH)) begin
                ostat_nxt = ST_FULL;
                odata_nxt = '0;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = IDX_W'(count_r);
                wr_data   = in_tdata;
                ostat_nxt = (count_r == '0) ? ST_INS_FIRST : ST_INS_END;
                odata_nxt = in_tdata;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_DELETE, OP_DISPLAY: begin
              if (count_r == '0) begin
                ovalid_nxt = 1'b1;
                olast_nxt  = 1'b1;
                ostat_nxt  = ST_EMPTY;
                odata_nxt  = '0;
              end else begin
                state_nxt = (in_tuser == OP_DELETE) ? S_SRCH_RD : S_DISP_RD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SRCH_RD: begin
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (rd_data_r == key_r) begin
          state_nxt = S_SHIFT_RD;
        end else if (at_end) begin
          ovalid_nxt = 1'b1;
          olast_nxt  = 1'b1;
          ostat_nxt  = ST_NOT_FOUND;
          odata_nxt  = '0;
          state_nxt  = S_IDLE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: begin
        if (at_end) begin
          count_nxt  = count_r - CNT_W'(1);
          ovalid_nxt = 1'b1;
          olast_nxt  = 1'b1;
          ostat_nxt  = ST_DELETED;
          odata_nxt  = key_r;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = rd_data_r;
        idx_nxt   = idx_r + IDX_W'(1);
        state_nxt = S_SHIFT_RD;
      end
      S_DISP_RD: begin
        state_nxt = S_DISP_OUT;
      end
      S_DISP_OUT: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          ostat_nxt  = ST_ELEMENT;
          odata_nxt  = rd_data_r;
          olast_nxt  = at_end;
          if (at_end) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_DISP_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    odata_r <= odata_nxt;
    ostat_r <= ostat_nxt;
    olast_r <= olast_nxt;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ols_checker.sv -----
// ols_checker: port-level assertions for ordered_list_store
// bound to the top level below; uses ols_pkg
`default_nettype none

module ols_checker import ols_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic [VAL_W-1:0] in_tdata,
  input wire logic [1:0]       in_tuser,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [VAL_W-1:0] out_tdata,
  input wire logic [2:0]       out_tuser,
  input wire logic             out_tlast
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // one item in flight
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
    (in_tuser == OP_INSERT || in_tuser == OP_DELETE || in_tuser == OP_DISPLAY)
    |=> !in_tready)
    else $error("new item taken while busy");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while result pending");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_ELEMENT) |-> out_tlast)
    else $error("single result without last");

  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_EMPTY || out_tuser == ST_NOT_FOUND ||
                   out_tuser == ST_FULL) |-> (out_tdata == '0))
    else $error("nonzero data on status result");

endmodule

bind ordered_list_store ols_checker u_ols_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ----- dv/ordered_list_store_test.sv -----
// ordered_list_store_test: self-checking bench for the ordered list store
// directed table, then weighted random items of all four op codes, stalled on both sides
// depends on ols_pkg and ordered_list_store
`default_nettype none

module ordered_list_store_test import ols_pkg::*;;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 134;
  localparam int QUIET_FROM   = 110;
  localparam int PHASE_LEN    = 40;
  localparam int NUM_ROWS     = 24;

  typedef struct packed {
    logic [2:0]       status;
    logic [VAL_W-1:0] item_value;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [VAL_W-1:0] value;
    logic [4:0]       reps;
    logic             typed;
    logic [2:0]       status;
    logic [VAL_W-1:0] exp_value;
  } row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [VAL_W-1:0] in_tdata;
  logic [1:0]       in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [VAL_W-1:0] out_tdata;
  logic [2:0]       out_tuser;
  logic             out_tlast;

  logic [VAL_W-1:0] list_contents[$];
  result_t          predicted[$];
  result_t          awaited_results[$];
  result_t          head_result;
  int               fail_count = 0;
  bit               quiet_mode = 1'b0;

  row_t directed_rows [NUM_ROWS] = '{
    '{OP_DISPLAY, 32'h0000_0000, 5'd1,  1'b1, ST_EMPTY,     32'h0000_0000},
    '{OP_DELETE,  32'h0000_0005, 5'd1,  1'b1, ST_EMPTY,     32'h0000_0000},
    '{OP_UNUSED,  32'hffff_ffff, 5'd1,  1'b0, ST_EMPTY,     32'h0000_0000},
    '{OP_INSERT,  32'h1357_9bdf, 5'd1,  1'b1, ST_INS_FIRST, 32'h1357_9bdf},
    '{OP_DELETE,  32'h1357_9bdf, 5'd1,  1'b1, ST_DELETED,   32'h1357_9bdf},
    '{OP_DISPLAY, 32'h0000_0000, 5'd1,  1'b1, ST_EMPTY,     32'h0000_0000},
    '{OP_INSERT,  32'h8000_0000, 5'd1,  1'b1, ST_INS_FIRST, 32'h8000_0000},
    '{OP_INSERT,  32'h7fff_ffff, 5'd1,  1'b1, ST_INS_END,   32'h7fff_ffff},
    '{OP_INSERT,  32'hffff_ffff, 5'd1,  1'b1, ST_INS_END,   32'hffff_ffff},
    '{OP_INSERT,  32'h0000_0000, 5'd1,  1'b1, ST_INS_END,   32'h0000_0000},
    '{OP_DISPLAY, 32'h0000_0000, 5'd1,  1'b0, ST_EMPTY,     32'h0000_0000},
    '{OP_DELETE,  32'h0001_2345, 5'd1,  1'b1, ST_NOT_FOUND, 32'h0000_0000},
    '{OP_DELETE,  32'h7fff_ffff, 5'd1,  1'b1, ST_DELETED,   32'h7fff_ffff},
    '{OP_INSERT,  32'h8000_0000, 5'd1,  1'b1, ST_INS_END,   32'h8000_0000},
    '{OP_DELETE,  32'h8000_0000, 5'd1,  1'b1, ST_DELETED,   32'h8000_0000},
    '{OP_DISPLAY, 32'h0000_0000, 5'd1,  1'b0, ST_EMPTY,     32'h0000_0000},
    '{OP_INSERT,  32'h55aa_0000, 5'd13, 1'b0, ST_EMPTY,     32'h0000_0000},
    '{OP_INSERT,  32'h2468_ace0, 5'd1,  1'b1, ST_FULL,      32'h0000_0000},
    '{OP_UNUSED,  32'h0000_0000, 5'd1,  1'b0, ST_EMPTY,     32'h0000_0000},
    '{OP_DISPLAY, 32'h0000_0000, 5'd1,  1'b0, ST_EMPTY,     32'h0000_0000},
    '{OP_DELETE,  32'h55aa_000c, 5'd1,  1'b1, ST_DELETED,   32'h55aa_000c},
    '{OP_DELETE,  32'hffff_ffff, 5'd1,  1'b1, ST_DELETED,   32'hffff_ffff},
    '{OP_INSERT,  32'h0f0f_0f0f, 5'd1,  1'b1, ST_INS_END,   32'h0f0f_0f0f},
    '{OP_DISPLAY, 32'h0000_0000, 5'd1,  1'b0, ST_EMPTY,     32'h0000_0000}
  };

  ordered_list_store u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void apply_list_op(input logic [1:0] op, input logic [VAL_W-1:0] val);
    int hit;
    hit = -1;
    predicted.delete();
    case (op)
      OP_INSERT: begin
        if (list_contents.size() >= LIST_DEPTH) begin
          predicted.push_back(result_t'{ST_FULL, 32'h0, 1'b1});
        end else begin
          predicted.push_back(result_t'{(list_contents.size() == 0) ? ST_INS_FIRST : ST_INS_END,
                                        val, 1'b1});
          list_contents.push_back(val);
        end
      end
      OP_DELETE: begin
        if (list_contents.size() == 0) begin
          predicted.push_back(result_t'{ST_EMPTY, 32'h0, 1'b1});
        end else begin
          for (int i = 0; i < list_contents.size(); i++) begin
            if (hit < 0 && list_contents[i] == val) hit = i;
          end
          if (hit < 0) begin
            predicted.push_back(result_t'{ST_NOT_FOUND, 32'h0, 1'b1});
          end else begin
            list_contents.delete(hit);
            predicted.push_back(result_t'{ST_DELETED, val, 1'b1});
          end
        end
      end
      OP_DISPLAY: begin
        if (list_contents.size() == 0) begin
          predicted.push_back(result_t'{ST_EMPTY, 32'h0, 1'b1});
        end else begin
          foreach (list_contents[i]) begin
            predicted.push_back(result_t'{ST_ELEMENT, list_contents[i],
                                          i == list_contents.size() - 1});
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [VAL_W-1:0] val,
                           input logic typed, input result_t typed_result);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= val;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    apply_list_op(op, val);
    if (typed) begin
      awaited_results.push_back(typed_result);
    end else begin
      foreach (predicted[i]) awaited_results.push_back(predicted[i]);
    end
  endtask

  task automatic rest_sender();
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected item: status %0d item_value %0d last %0d",
               out_tuser, $signed(out_tdata), out_tlast);
        fail_count++;
      end else begin
        head_result = awaited_results.pop_front();
        if (out_tuser !== head_result.status) begin
          $error("status mismatch: expected %0d, actual %0d", head_result.status, out_tuser);
          fail_count++;
        end
        if (out_tdata !== head_result.item_value) begin
          $error("item_value mismatch: expected %0d, actual %0d",
                 $signed(head_result.item_value), $signed(out_tdata));
          fail_count++;
        end
        if (out_tlast !== head_result.last) begin
          $error("last mismatch: expected %0d, actual %0d", head_result.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    out_tready <= 1'b0;
    forever begin
      if (quiet_mode) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_tready <= 1'b1;
        repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 16)) @(posedge clk);
      end
    end
  end

  initial begin
    int counted;
    int sel;
    logic [1:0] op;
    logic [VAL_W-1:0] val;
    counted = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_INSERT;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        send_item(directed_rows[r].op, directed_rows[r].value + k, directed_rows[r].typed,
                  result_t'{directed_rows[r].status, directed_rows[r].exp_value, 1'b1});
        rest_sender();
      end
    end

    while (counted < RANDOM_ITEMS) begin
      if (counted >= QUIET_FROM) quiet_mode = 1'b1;
      if (counted % PHASE_LEN == 0) begin
        // hold off until the list store has drained
        in_tvalid <= 1'b0;
        do @(posedge clk); while (awaited_results.size() != 0);
      end
      sel = $urandom_range(0, 99);
      if (sel < 3) op = OP_UNUSED;
      else if (sel < 15) op = OP_DISPLAY;
      else if (sel < (((counted / PHASE_LEN) % 2 == 0) ? 72 : 40)) op = OP_INSERT;
      else op = OP_DELETE;
      val = $urandom;
      sel = $urandom_range(0, 9);
      if (sel < 2) val = $urandom_range(0, 7);
      else if (sel == 2) val = ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      else if (op == OP_DELETE && sel > 4 && list_contents.size() != 0)
        val = list_contents[$urandom_range(0, list_contents.size() - 1)];
      send_item(op, val, 1'b0, result_t'{ST_EMPTY, 32'h0, 1'b1});
      if (op != OP_UNUSED) counted++;
      rest_sender();
    end

    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (48) @(posedge clk);
    if (fail_count == 0) begin
      $display("** ordered_list_store: PASSED **");
    end else begin
      $display("** ordered_list_store: FAILED **");
    end
    $finish;
  end

  initial begin
    #3200000;
    $display("** ordered_list_store: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
